>>> rtl/fvn_pkg.sv
`timescale 1ns / 1ps
package fvn_pkg;

  localparam int MAX_OCTAVES_DEF = 8;
  localparam int FRAC_BITS_DEF   = 16;

  // corner hash constants
  localparam logic [31:0] HASH_PX  = 32'd374761393;
  localparam logic [31:0] HASH_PY  = 32'd668265263;
  localparam logic [31:0] HASH_PS  = 32'd2246822519;
  localparam logic [31:0] HASH_MIX = 32'd1274126177;

  // output scaling: Q.23 sum times 2^32 reciprocal, down to Q1.16
  localparam int          RECIP_BITS  = 32;
  localparam int          RECIP_SHIFT = RECIP_BITS + 23 - 16;
  localparam logic [17:0] OUT_LIMIT   = 18'd65536;

  // configuration register indexes
  localparam logic [1:0] CFG_FREQUENCY    = 2'd0;
  localparam logic [1:0] CFG_OCTAVE_COUNT = 2'd1;
  localparam logic [1:0] CFG_SEED         = 2'd2;

endpackage

>>> rtl/fvn_in_if.sv
`timescale 1ns / 1ps
interface fvn_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;

  modport source  (output valid, x_coord, y_coord, input ready);
  modport sink    (input valid, x_coord, y_coord, output ready);
  modport monitor (input valid, ready, x_coord, y_coord);
endinterface

>>> rtl/fvn_out_if.sv
`timescale 1ns / 1ps
interface fvn_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] noise_value;

  modport source  (output valid, noise_value, input ready);
  modport sink    (input valid, noise_value, output ready);
  modport monitor (input valid, ready, noise_value);
endinterface

>>> rtl/fvn_cfg_if.sv
`timescale 1ns / 1ps
interface fvn_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [31:0] wdata;

  modport source  (output valid, reg_index, wdata, input ready);
  modport sink    (input valid, reg_index, wdata, output ready);
  modport monitor (input valid, ready, reg_index, wdata);
endinterface

>>> rtl/fvn_cell.sv
`timescale 1ns / 1ps
// One octave: 10 stages. Lattice coords and seed go on to the next cell after
// stage 1 (shifted one place, seed + 1); the running sum goes on after stage 10.
module fvn_cell #(
  parameter int K           = 0,
  parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF,
  parameter int FRAC_BITS   = fvn_pkg::FRAC_BITS_DEF,
  localparam int NW = $clog2(MAX_OCTAVES + 1),
  localparam int SW = 24 + MAX_OCTAVES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [NW-1:0]        n_sat,
  input  logic                 v_in,
  input  logic [63:0]          px_in,
  input  logic [63:0]          py_in,
  input  logic [31:0]          s_in,
  input  logic signed [SW-1:0] sum_in,
  output logic                 v_fwd,
  output logic [63:0]          px_fwd,
  output logic [63:0]          py_fwd,
  output logic [31:0]          s_fwd,
  output logic                 v_done,
  output logic signed [SW-1:0] sum_out
);

  localparam int F   = FRAC_BITS;
  localparam int PBW = 27 + F;
  localparam logic [31:0] CORNER_OFF [4] = '{32'd0, fvn_pkg::HASH_PX, fvn_pkg::HASH_PY,
                                              fvn_pkg::HASH_PX + fvn_pkg::HASH_PY};

  logic [9:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[8:0], v_in};
    end
  end

  assign v_fwd  = vld[0];
  assign v_done = vld[9];

  // stage 1: hash products, t squared
  logic [F-1:0]   tx, ty;
  logic [2*F-1:0] sqx, sqy;
  logic [31:0]    s1_ha, s1_hb, s1_hc;
  logic [F-1:0]   s1_t2x, s1_t2y, s1_tx, s1_ty;

  assign tx  = px_in[31 -: F];
  assign ty  = py_in[31 -: F];
  assign sqx = (2*F)'(tx) * (2*F)'(tx);
  assign sqy = (2*F)'(ty) * (2*F)'(ty);

  // stage 2: hash base, smoothstep
  logic [F+1:0]   fx, fy;
  logic [2*F+1:0] smpx, smpy;
  logic [31:0]    s2_hs;
  logic [F:0]     s2_smx, s2_smy;

  assign fx   = (F+2)'(3 << F) - {1'b0, s1_tx, 1'b0};
  assign fy   = (F+2)'(3 << F) - {1'b0, s1_ty, 1'b0};
  assign smpx = (2*F+2)'(s1_t2x) * (2*F+2)'(fx);
  assign smpy = (2*F+2)'(s1_t2y) * (2*F+2)'(fy);

  // stages 3..5: per-corner hash finish; corner order 00, 10, 01, 11
  logic [31:0]        hc [4];
  logic [31:0]        gx [4];
  logic [31:0]        s3_m [4];
  logic [31:0]        s4_g [4];
  logic signed [23:0] s5_c [4];
  logic [F:0]         s3_smx, s3_smy, s4_smx, s4_smy, s5_smx, s5_smy;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      hc[c] = s2_hs + CORNER_OFF[c];
      gx[c] = s4_g[c] ^ (s4_g[c] >> 16);
    end
  end

  // stages 6..9: bilinear blend
  logic signed [24:0]    dxb, dxt, dy;
  logic signed [PBW-1:0] pb, pt, pv;
  logic signed [PBW-1:0] s6_pb, s6_pt, s8_pv;
  logic signed [23:0]    s6_c0, s6_c2, s7_bot, s7_top, s8_bot, s9_val;
  logic [F:0]            s6_smy, s7_smy;

  assign dxb = 25'(s5_c[1]) - 25'(s5_c[0]);
  assign dxt = 25'(s5_c[3]) - 25'(s5_c[2]);
  assign pb  = PBW'(dxb) * PBW'($signed({1'b0, s5_smx}));
  assign pt  = PBW'(dxt) * PBW'($signed({1'b0, s5_smx}));
  assign dy  = 25'(s7_top) - 25'(s7_bot);
  assign pv  = PBW'(dy) * PBW'($signed({1'b0, s7_smy}));

  // stage 10: weighted add into the running sum
  logic signed [SW-1:0] term;

  assign term = (n_sat > NW'(K)) ? (SW'(s9_val) <<< (MAX_OCTAVES - 1 - K)) : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ha  <= px_in[63:32] * fvn_pkg::HASH_PX;
      s1_hb  <= py_in[63:32] * fvn_pkg::HASH_PY;
      s1_hc  <= s_in * fvn_pkg::HASH_PS;
      s1_t2x <= sqx[2*F-1:F];
      s1_t2y <= sqy[2*F-1:F];
      s1_tx  <= tx;
      s1_ty  <= ty;
      px_fwd <= px_in << 1;
      py_fwd <= py_in << 1;
      s_fwd  <= s_in + 32'd1;

      s2_hs  <= s1_ha + s1_hb + s1_hc;
      s2_smx <= smpx[2*F:F];
      s2_smy <= smpy[2*F:F];

      for (int c = 0; c < 4; c++) begin
        s3_m[c] <= hc[c] ^ (hc[c] >> 13);
        s4_g[c] <= s3_m[c] * fvn_pkg::HASH_MIX;
        s5_c[c] <= $signed({~gx[c][31], gx[c][30:8]});
      end
      s3_smx <= s2_smx;
      s3_smy <= s2_smy;
      s4_smx <= s3_smx;
      s4_smy <= s3_smy;
      s5_smx <= s4_smx;
      s5_smy <= s4_smy;

      s6_pb  <= pb;
      s6_pt  <= pt;
      s6_c0  <= s5_c[0];
      s6_c2  <= s5_c[2];
      s6_smy <= s5_smy;

      s7_bot <= s6_c0 + 24'(s6_pb >>> F);
      s7_top <= s6_c2 + 24'(s6_pt >>> F);
      s7_smy <= s6_smy;

      s8_pv  <= pv;
      s8_bot <= s7_bot;

      s9_val <= s8_bot + 24'(s8_pv >>> F);

      sum_out <= sum_in + term;
    end
  end

endmodule

>>> rtl/fvn_norm.sv
`timescale 1ns / 1ps
// Scale the weighted sum by the reciprocal of the total weight: 3 stages,
// the magnitude product split in two halves.
module fvn_norm #(
  parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF,
  localparam int NW = $clog2(MAX_OCTAVES + 1),
  localparam int SW = 24 + MAX_OCTAVES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 v_in,
  input  logic signed [SW-1:0] sum_in,
  input  logic [NW-1:0]        n_sat,
  input  logic                 freq_zero,
  output logic                 v_out,
  output logic signed [17:0]   nv_out
);

  localparam int MW = 23 + MAX_OCTAVES;
  localparam int RW = 34 - MAX_OCTAVES;
  localparam int PW = MW + RW;

  logic [RW-1:0] rtab [MAX_OCTAVES+1];

  assign rtab[0] = '0;
  for (genvar i = 1; i <= MAX_OCTAVES; i++) begin : g_recip
    localparam longint unsigned WT = (64'd1 << MAX_OCTAVES) - (64'd1 << (MAX_OCTAVES - i));
    localparam logic [RW-1:0] RV = RW'((64'd1 << fvn_pkg::RECIP_BITS) / WT);
    assign rtab[i] = RV;
  end

  logic [2:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], v_in};
    end
  end

  assign v_out = vld[2];

  logic             n1_neg, n1_zero, n2_neg, n2_zero;
  logic [MW-1:0]    n1_mag;
  logic [RW-1:0]    n1_r;
  logic [RW+15:0]   n2_lo;
  logic [PW-17:0]   n2_hi;
  logic [PW-1:0]    prod;
  logic [17:0]      q, qc;

  assign prod = (PW'(n2_hi) << 16) + PW'(n2_lo);
  assign q    = prod[PW-1:fvn_pkg::RECIP_SHIFT];
  assign qc   = (q > fvn_pkg::OUT_LIMIT) ? fvn_pkg::OUT_LIMIT : q;

  always_ff @(posedge clk) begin
    if (en) begin
      n1_neg  <= sum_in[SW-1];
      n1_mag  <= MW'(sum_in[SW-1] ? -sum_in : sum_in);
      n1_r    <= rtab[n_sat];
      n1_zero <= freq_zero || (n_sat == '0);

      n2_lo   <= (RW+16)'(n1_mag[15:0]) * (RW+16)'(n1_r);
      n2_hi   <= (PW-16)'(n1_mag[MW-1:16]) * (PW-16)'(n1_r);
      n2_neg  <= n1_neg;
      n2_zero <= n1_zero;

      nv_out  <= n2_zero ? '0 : (n2_neg ? -$signed(qc) : $signed(qc));
    end
  end

endmodule

>>> rtl/fractal_value_noise_2d.sv
`timescale 1ns / 1ps
// Channel  Modport  Beat payload                       Accepted when
// in_pt    sink     x_coord, y_coord (Q16.16 signed)   in_pt.valid && in_pt.ready
// out_nv   source   noise_value (Q1.16 signed)         out_nv.valid && out_nv.ready
// cfg      sink     reg_index, wdata                   cfg.valid (ready always high)
//
// One point per cycle sustained while out_nv does not stall. From accept to
// out_nv.valid: 1 scale multiply, a row of octave cells each a register behind its
// neighbor (10 stages each), 3 normalize stages, output register.
// Reset (rst, sync) clears valid bits and loads register defaults; no clearing pass.
// A stall on out_nv fills the skid beat, then freezes the whole pipe and drops
// in_pt.ready until the skid drains.
module fractal_value_noise_2d #(
  parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF,
  parameter int FRAC_BITS   = fvn_pkg::FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst,
  fvn_in_if.sink    in_pt,
  fvn_out_if.source out_nv,
  fvn_cfg_if.sink   cfg
);

  localparam int NW = $clog2(MAX_OCTAVES + 1);
  localparam int SW = 24 + MAX_OCTAVES;

  // config registers
  logic [23:0] frequency;
  logic [3:0]  octave_count;
  logic [31:0] seed;
  logic [NW-1:0] n_sat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frequency    <= 24'd65536;
      octave_count <= 4'd4;
      seed         <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        fvn_pkg::CFG_FREQUENCY:    frequency    <= cfg.wdata[23:0];
        fvn_pkg::CFG_OCTAVE_COUNT: octave_count <= cfg.wdata[3:0];
        fvn_pkg::CFG_SEED:         seed         <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // counts above the cell row saturate
  assign n_sat = (octave_count > MAX_OCTAVES) ? NW'(MAX_OCTAVES) : NW'(octave_count);

  // pipe advances unless a beat is parked in the skid
  logic en;
  logic sk_valid;

  assign en          = !sk_valid;
  assign in_pt.ready = en;

  // front: lattice coordinate = coord * frequency, 32 fraction bits
  logic signed [56:0] mx, my;
  logic               f_v;
  logic [63:0]        f_px, f_py;

  assign mx = 57'(in_pt.x_coord) * 57'($signed({1'b0, frequency}));
  assign my = 57'(in_pt.y_coord) * 57'($signed({1'b0, frequency}));

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (en) begin
      f_v <= in_pt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_px <= 64'(mx);
      f_py <= 64'(my);
    end
  end

  // octave cell row
  logic                 ch_v  [MAX_OCTAVES+1];
  logic [63:0]          ch_px [MAX_OCTAVES+1];
  logic [63:0]          ch_py [MAX_OCTAVES+1];
  logic [31:0]          ch_s  [MAX_OCTAVES+1];
  logic signed [SW-1:0] ch_sum[MAX_OCTAVES+1];
  logic                 ch_done[MAX_OCTAVES];

  assign ch_v[0]   = f_v;
  assign ch_px[0]  = f_px;
  assign ch_py[0]  = f_py;
  assign ch_s[0]   = seed;
  assign ch_sum[0] = '0;

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_cell
    fvn_cell #(
      .K(k), .MAX_OCTAVES(MAX_OCTAVES), .FRAC_BITS(FRAC_BITS)
    ) u_cell (
      .clk(clk), .rst(rst), .en(en), .n_sat(n_sat),
      .v_in(ch_v[k]), .px_in(ch_px[k]), .py_in(ch_py[k]), .s_in(ch_s[k]),
      .sum_in(ch_sum[k]),
      .v_fwd(ch_v[k+1]), .px_fwd(ch_px[k+1]), .py_fwd(ch_py[k+1]), .s_fwd(ch_s[k+1]),
      .v_done(ch_done[k]), .sum_out(ch_sum[k+1])
    );
  end

  // normalize
  logic               pv;
  logic signed [17:0] pd;

  fvn_norm #(.MAX_OCTAVES(MAX_OCTAVES)) u_norm (
    .clk(clk), .rst(rst), .en(en),
    .v_in(ch_done[MAX_OCTAVES-1]), .sum_in(ch_sum[MAX_OCTAVES]),
    .n_sat(n_sat), .freq_zero(frequency == '0),
    .v_out(pv), .nv_out(pd)
  );

  // output register plus skid beat
  logic               o_valid;
  logic signed [17:0] o_data, sk_data;
  logic               take;

  assign take               = !o_valid || out_nv.ready;
  assign out_nv.valid       = o_valid;
  assign out_nv.noise_value = o_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid  <= 1'b0;
      sk_valid <= 1'b0;
    end else if (sk_valid) begin
      if (take) begin
        o_valid  <= 1'b1;
        sk_valid <= 1'b0;
      end
    end else if (pv) begin
      if (take) begin
        o_valid <= 1'b1;
      end else begin
        sk_valid <= 1'b1;
      end
    end else if (take) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_valid) begin
      if (take) o_data <= sk_data;
    end else if (pv) begin
      if (take) o_data  <= pd;
      else      sk_data <= pd;
    end
  end

  // skid holds only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    sk_valid |-> o_valid) else $error("skid beat without output beat");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> (o_data <= 18'sd65536 && o_data >= -18'sd65536))
    else $error("noise_value out of range");

  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    (sk_valid && !out_nv.ready) |=> (sk_valid && $stable(sk_data)))
    else $error("skid beat lost under stall");

endmodule
